// ===== sv/swpt_pkg.sv =====
// swpt_pkg: shared types, codes and constants for the stopwatch / pomodoro timer
// no dependencies; imported by every module of the block but swpt_lap_cell

package swpt_pkg;

  // lap ring depth and derived widths
  localparam int unsigned LAP_DEPTH = 16;
  localparam int unsigned FILL_W    = $clog2(LAP_DEPTH + 1);

  localparam int unsigned MS_PER_SEC = 1000;
  localparam int unsigned SEC_PER_MIN = 60;
  localparam int unsigned MS_PER_MIN = SEC_PER_MIN * MS_PER_SEC;

  localparam logic [15:0] LAP_TOTAL_MAX = 16'hFFFF;

  // configuration register indexes
  localparam logic [1:0] CFG_FOCUS  = 2'd0;
  localparam logic [1:0] CFG_SHORT  = 2'd1;
  localparam logic [1:0] CFG_LONG   = 2'd2;
  localparam logic [1:0] CFG_CYCLES = 2'd3;

  localparam logic [7:0] RST_FOCUS  = 8'd25;
  localparam logic [7:0] RST_SHORT  = 8'd5;
  localparam logic [7:0] RST_LONG   = 8'd15;
  localparam logic [3:0] RST_CYCLES = 4'd4;

  // input opcodes
  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_MODE  = 2'd1,
    OP_START = 2'd2,
    OP_LAP   = 2'd3
  } opcode_t;

  // pomodoro phases
  typedef enum logic [1:0] {
    PH_FOCUS = 2'd0,
    PH_SHORT = 2'd1,
    PH_LONG  = 2'd2
  } phase_t;

  typedef struct packed {
    logic [7:0] focus_minutes;
    logic [7:0] short_break_minutes;
    logic [7:0] long_break_minutes;
    logic [3:0] cycles_before_long_break;
  } cfg_t;

  // commands from the timer control to the lap chain
  typedef struct packed {
    logic rec;
    logic clr;
  } lap_cmd_t;

  // post-step timer status
  typedef struct packed {
    logic [31:0] elapsed_ms;
    logic [23:0] remaining_ms;
    logic        pomodoro_mode;
    logic        is_running;
    logic [1:0]  phase_now;
    logic        phase_done;
    logic        alert_pulse;
    logic [3:0]  round_in_cycle;
  } status_t;

  // phase length in ms, zero minutes treated as one
  function automatic logic [23:0] phase_ms(input cfg_t cfg, input phase_t ph);
    logic [7:0] m;
    case (ph)
      PH_FOCUS: m = cfg.focus_minutes;
      PH_SHORT: m = cfg.short_break_minutes;
      default:  m = cfg.long_break_minutes;
    endcase
    if (m == 8'd0) m = 8'd1;
    return 24'(m) * 24'(MS_PER_MIN);
  endfunction

endpackage

// ===== sv/swpt_lap_cell.sv =====
// swpt_lap_cell: one slot of the lap chain, takes its neighbor's value on a shift
// depends on nothing but the clock

module swpt_lap_cell (
  input  logic        clk,
  input  logic        shift,
  input  logic [31:0] d_in,
  output logic [31:0] q,
  output logic [31:0] q_next
);

  // hold or take the value from the newer neighbor
  assign q_next = shift ? d_in : q;

  always_ff @(posedge clk) begin
    q <= q_next;
  end

endmodule

// ===== sv/swpt_lap_chain.sv =====
// swpt_lap_chain: row of lap cells, newest in cell 0, with fill and total counters
// depends on swpt_pkg and swpt_lap_cell

module swpt_lap_chain (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  swpt_pkg::lap_cmd_t cmd,
  input  logic [31:0]       lap_in,
  input  logic [3:0]        lap_index,
  output logic [15:0]       laps_recorded_next,
  output logic [4:0]        laps_held_next,
  output logic [31:0]       lap_time_next
);
  import swpt_pkg::*;

  logic [31:0]       cell_q    [LAP_DEPTH];
  logic [31:0]       cell_next [LAP_DEPTH];
  logic [FILL_W-1:0] fill;
  logic [FILL_W-1:0] fill_next;
  logic [15:0]       lap_total;
  logic [15:0]       lap_total_next;
  logic              shift;
  logic [31:0]       sel;

  assign shift = step && cmd.rec;

  // the chain: each cell hands its value to the next older one
  for (genvar i = 0; i < LAP_DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_head
      swpt_lap_cell u_cell (
        .clk    (clk),
        .shift  (shift),
        .d_in   (lap_in),
        .q      (cell_q[i]),
        .q_next (cell_next[i])
      );
    end else begin : g_body
      swpt_lap_cell u_cell (
        .clk    (clk),
        .shift  (shift),
        .d_in   (cell_q[i-1]),
        .q      (cell_q[i]),
        .q_next (cell_next[i])
      );
    end
  end

  // fill count and saturating lap total
  always_comb begin
    fill_next      = fill;
    lap_total_next = lap_total;
    if (step) begin
      if (cmd.clr) begin
        fill_next      = '0;
        lap_total_next = '0;
      end else if (cmd.rec) begin
        if (32'(fill) < LAP_DEPTH) fill_next = fill + 1'b1;
        if (lap_total != LAP_TOTAL_MAX) lap_total_next = lap_total + 16'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill      <= '0;
      lap_total <= '0;
    end else begin
      fill      <= fill_next;
      lap_total <= lap_total_next;
    end
  end

  // select the requested lap from the post-step cells
  always_comb begin
    sel = '0;
    for (int i = 0; i < LAP_DEPTH; i++) begin
      if (32'(lap_index) == 32'(i)) sel = cell_next[i];
    end
  end

  assign lap_time_next      = (32'(lap_index) < 32'(fill_next)) ? sel : 32'd0;
  assign laps_held_next     = 5'(fill_next);
  assign laps_recorded_next = lap_total_next;

endmodule

// ===== sv/swpt_ctrl.sv =====
// swpt_ctrl: timer state (mode, run, elapsed, phase, done, round) and its step logic
// depends on swpt_pkg; drives lap commands to swpt_lap_chain

module swpt_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               step,
  input  swpt_pkg::opcode_t  opcode,
  input  swpt_pkg::cfg_t     cfg,
  output swpt_pkg::lap_cmd_t cmd,
  output logic [31:0]        lap_value,
  output swpt_pkg::status_t  status_next
);
  import swpt_pkg::*;

  logic        mode_bit;
  logic        mode_bit_next;
  logic        run_bit;
  logic        run_bit_next;
  logic [31:0] elapsed;
  logic [31:0] elapsed_next;
  phase_t      phase;
  phase_t      phase_next;
  logic        done_bit;
  logic        done_bit_next;
  logic [3:0]  round_cnt;
  logic [3:0]  round_cnt_next;
  logic        alert;
  logic        adv;
  logic        restart;
  logic [31:0] elapsed_inc;
  logic [23:0] dur_cur;
  logic [23:0] dur_next;
  logic [3:0]  cyc;
  logic [4:0]  round_inc;

  assign dur_cur     = phase_ms(cfg, phase);
  assign elapsed_inc = elapsed + 32'd1;
  assign cyc = (cfg.cycles_before_long_break == 4'd0) ? 4'd1 : cfg.cycles_before_long_break;
  assign round_inc = 5'(round_cnt) + 5'd1;

  // run, elapsed, done, mode and lap commands
  always_comb begin
    mode_bit_next = mode_bit;
    run_bit_next  = run_bit;
    elapsed_next  = elapsed;
    done_bit_next = done_bit;
    alert         = 1'b0;
    adv           = 1'b0;
    restart       = 1'b0;
    cmd           = '0;
    if (step) begin
      case (opcode)
        OP_TICK: begin
          if (run_bit) begin
            if (mode_bit && (elapsed_inc >= 32'(dur_cur))) begin
              run_bit_next  = 1'b0;
              done_bit_next = 1'b1;
              elapsed_next  = 32'(dur_cur);
              alert         = 1'b1;
            end else begin
              elapsed_next = elapsed_inc;
            end
          end
        end
        OP_MODE: begin
          mode_bit_next = ~mode_bit;
          cmd.clr       = 1'b1;
          restart       = 1'b1;
        end
        OP_START: begin
          if (mode_bit && done_bit) adv = 1'b1;
          else run_bit_next = ~run_bit;
        end
        OP_LAP: begin
          if (mode_bit) begin
            if (run_bit || done_bit) adv = 1'b1;
            else restart = 1'b1;
          end else if (run_bit) begin
            cmd.rec = 1'b1;
          end else begin
            elapsed_next = '0;
            cmd.clr      = 1'b1;
          end
        end
        default: ;
      endcase
      // arming a new phase or restarting the cycle leaves the timer paused at zero
      if (adv || restart) begin
        run_bit_next  = 1'b0;
        done_bit_next = 1'b0;
        elapsed_next  = '0;
      end
    end
  end

  // phase sequencing: next state
  always_comb begin
    phase_next     = phase;
    round_cnt_next = round_cnt;
    if (restart) begin
      phase_next     = PH_FOCUS;
      round_cnt_next = '0;
    end else if (adv) begin
      case (phase)
        PH_FOCUS: begin
          if (round_inc >= 5'(cyc)) begin
            round_cnt_next = '0;
            phase_next     = PH_LONG;
          end else begin
            round_cnt_next = round_inc[3:0];
            phase_next     = PH_SHORT;
          end
        end
        default: phase_next = PH_FOCUS;
      endcase
    end
  end

  // status outputs after the step
  always_comb begin
    dur_next                   = phase_ms(cfg, phase_next);
    status_next.elapsed_ms     = elapsed_next;
    status_next.remaining_ms   = '0;
    if (mode_bit_next && (elapsed_next < 32'(dur_next))) begin
      status_next.remaining_ms = dur_next - elapsed_next[23:0];
    end
    status_next.pomodoro_mode  = mode_bit_next;
    status_next.is_running     = run_bit_next;
    status_next.phase_now      = phase_next;
    status_next.phase_done     = done_bit_next;
    status_next.alert_pulse    = alert;
    status_next.round_in_cycle = round_cnt_next;
  end

  assign lap_value = elapsed;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_bit  <= 1'b0;
      run_bit   <= 1'b0;
      elapsed   <= '0;
      phase     <= PH_FOCUS;
      done_bit  <= 1'b0;
      round_cnt <= '0;
    end else begin
      mode_bit  <= mode_bit_next;
      run_bit   <= run_bit_next;
      elapsed   <= elapsed_next;
      phase     <= phase_next;
      done_bit  <= done_bit_next;
      round_cnt <= round_cnt_next;
    end
  end

endmodule

// ===== sv/stopwatch_pomodoro_timer_unit.sv =====
// stopwatch_pomodoro_timer_unit: top level, config registers, output word register
// depends on swpt_pkg, swpt_ctrl, swpt_lap_chain (and swpt_lap_cell below it)
//
//   channel  handshake               payload
//   in       in_valid / in_ready     opcode, lap_index
//   out      out_valid / out_ready   elapsed_ms .. lap_time (11 fields)
//   cfg      cfg_we                  cfg_index, cfg_data
//
// one word in per cycle while in_ready is high; its result word appears in the output register on
// the next cycle. state updates and the lap chain shift in the accepting cycle.
// rst (synchronous) clears the timer state, lap counts and config to defaults;
// lap cells hold no reset and are read only once written.
// while a result word waits on out_ready, in_ready stays low.

module stopwatch_pomodoro_timer_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  opcode,
  input  logic [3:0]  lap_index,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] elapsed_ms,
  output logic [23:0] remaining_ms,
  output logic        pomodoro_mode,
  output logic        is_running,
  output logic [1:0]  phase_now,
  output logic        phase_done,
  output logic        alert_pulse,
  output logic [3:0]  round_in_cycle,
  output logic [15:0] laps_recorded,
  output logic [4:0]  laps_held,
  output logic [31:0] lap_time,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);
  import swpt_pkg::*;

  cfg_t        cfg;
  logic        step;
  lap_cmd_t    cmd;
  logic [31:0] lap_value;
  status_t     status_next;
  logic [15:0] laps_recorded_next;
  logic [4:0]  laps_held_next;
  logic [31:0] lap_time_next;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.focus_minutes            <= RST_FOCUS;
      cfg.short_break_minutes      <= RST_SHORT;
      cfg.long_break_minutes       <= RST_LONG;
      cfg.cycles_before_long_break <= RST_CYCLES;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FOCUS:  cfg.focus_minutes            <= cfg_data;
        CFG_SHORT:  cfg.short_break_minutes      <= cfg_data;
        CFG_LONG:   cfg.long_break_minutes       <= cfg_data;
        CFG_CYCLES: cfg.cycles_before_long_break <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // handshake: take a word when the output register is free or draining
  assign in_ready = !out_valid || out_ready;
  assign step     = in_valid && in_ready;

  swpt_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .step        (step),
    .opcode      (opcode_t'(opcode)),
    .cfg         (cfg),
    .cmd         (cmd),
    .lap_value   (lap_value),
    .status_next (status_next)
  );

  swpt_lap_chain u_laps (
    .clk                (clk),
    .rst                (rst),
    .step               (step),
    .cmd                (cmd),
    .lap_in             (lap_value),
    .lap_index          (lap_index),
    .laps_recorded_next (laps_recorded_next),
    .laps_held_next     (laps_held_next),
    .lap_time_next      (lap_time_next)
  );

  // output word valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // output word payload
  always_ff @(posedge clk) begin
    if (step) begin
      elapsed_ms     <= status_next.elapsed_ms;
      remaining_ms   <= status_next.remaining_ms;
      pomodoro_mode  <= status_next.pomodoro_mode;
      is_running     <= status_next.is_running;
      phase_now      <= status_next.phase_now;
      phase_done     <= status_next.phase_done;
      alert_pulse    <= status_next.alert_pulse;
      round_in_cycle <= status_next.round_in_cycle;
      laps_recorded  <= laps_recorded_next;
      laps_held      <= laps_held_next;
      lap_time       <= lap_time_next;
    end
  end

  // an accepted word always shows up in the output register next cycle
  a_step_fills_out: assert property (@(posedge clk) disable iff (rst)
    step |=> out_valid)
    else $error("accepted word did not reach the output register");

  // an expiry alert only comes with a stopped, done pomodoro phase
  a_alert_state: assert property (@(posedge clk) disable iff (rst)
    out_valid && alert_pulse |-> phase_done && !is_running && pomodoro_mode)
    else $error("alert without a finished pomodoro phase");

  // stopwatch mode reports no remaining time
  a_sw_remaining: assert property (@(posedge clk) disable iff (rst)
    out_valid && !pomodoro_mode |-> remaining_ms == 24'd0)
    else $error("remaining time in stopwatch mode");

  // a lap time is only reported for a held slot
  a_lap_held: assert property (@(posedge clk) disable iff (rst)
    out_valid && lap_time != 32'd0 |-> laps_held != 5'd0)
    else $error("lap time reported with no laps held");

endmodule

// ===== tb/sv/stopwatch_pomodoro_timer_unit_test.sv =====
// stopwatch_pomodoro_timer_unit_test: self-checking bench for the stopwatch / pomodoro timer
// depends on swpt_pkg and stopwatch_pomodoro_timer_unit; keeps its own timer model and
// checks every result word field by field against it

`timescale 1ns / 100ps

module stopwatch_pomodoro_timer_unit_test;
  import swpt_pkg::*;

  localparam int WATCHDOG_LIMIT = 1000;

  // one expected result word
  typedef struct packed {
    logic [31:0] elapsed;
    logic [23:0] remaining;
    logic        pomo;
    logic        running;
    logic [1:0]  phase;
    logic        done;
    logic        alert;
    logic [3:0]  round;
    logic [15:0] lap_total;
    logic [4:0]  lap_fill;
    logic [31:0] lap_val;
  } timer_word_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  opcode = OP_TICK;
  logic [3:0]  lap_index = 4'd0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] elapsed_ms;
  logic [23:0] remaining_ms;
  logic        pomodoro_mode;
  logic        is_running;
  logic [1:0]  phase_now;
  logic        phase_done;
  logic        alert_pulse;
  logic [3:0]  round_in_cycle;
  logic [15:0] laps_recorded;
  logic [4:0]  laps_held;
  logic [31:0] lap_time;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = CFG_FOCUS;
  logic [7:0]  cfg_data = 8'd0;

  stopwatch_pomodoro_timer_unit dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .opcode         (opcode),
    .lap_index      (lap_index),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .elapsed_ms     (elapsed_ms),
    .remaining_ms   (remaining_ms),
    .pomodoro_mode  (pomodoro_mode),
    .is_running     (is_running),
    .phase_now      (phase_now),
    .phase_done     (phase_done),
    .alert_pulse    (alert_pulse),
    .round_in_cycle (round_in_cycle),
    .laps_recorded  (laps_recorded),
    .laps_held      (laps_held),
    .lap_time       (lap_time),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  // timer model state
  logic        m_pomo = 1'b0;
  logic        m_run = 1'b0;
  logic        m_done = 1'b0;
  logic [31:0] m_elapsed = '0;
  phase_t      m_phase = PH_FOCUS;
  logic [3:0]  m_round = '0;
  logic [15:0] m_laps_total = '0;
  logic [31:0] m_lap_ring [LAP_DEPTH];
  int unsigned m_lap_fill = 0;
  int unsigned m_lap_head = 0;

  // configuration copy
  logic [7:0]  c_focus = RST_FOCUS;
  logic [7:0]  c_short = RST_SHORT;
  logic [7:0]  c_long = RST_LONG;
  logic [3:0]  c_cycles = RST_CYCLES;

  timer_word_t words_due[$];
  int          mismatches = 0;
  int          quiet_cycles = 0;
  int          stall_left = 0;
  bit          gaps_on = 1'b1;
  bit          stalls_on = 1'b1;

  initial begin
    forever #2 clk = ~clk;
  end

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(4, 24);
  endfunction

  function automatic logic [31:0] phase_len(phase_t ph);
    logic [31:0] mins;
    case (ph)
      PH_FOCUS: mins = c_focus;
      PH_SHORT: mins = c_short;
      default:  mins = c_long;
    endcase
    if (mins == 0) mins = 1;
    return mins * MS_PER_MIN;
  endfunction

  function automatic void clear_laps();
    m_lap_fill = 0;
    m_lap_head = 0;
    m_laps_total = '0;
  endfunction

  function automatic void clear_cycle();
    m_phase = PH_FOCUS;
    m_round = '0;
    m_run = 1'b0;
    m_done = 1'b0;
    m_elapsed = '0;
  endfunction

  // move to the next pomodoro phase, paused
  function automatic void advance_phase();
    int unsigned cyc;
    int unsigned r;
    if (m_phase == PH_FOCUS) begin
      cyc = (c_cycles == 0) ? 1 : c_cycles;
      r = m_round + 1;
      if (r >= cyc) begin
        m_round = '0;
        m_phase = PH_LONG;
      end else begin
        m_round = r[3:0];
        m_phase = PH_SHORT;
      end
    end else begin
      m_phase = PH_FOCUS;
    end
    m_run = 1'b0;
    m_done = 1'b0;
    m_elapsed = '0;
  endfunction

  // apply one input word to the model and return the status it leaves
  function automatic timer_word_t step_timer(opcode_t op, logic [3:0] idx);
    timer_word_t w;
    logic [31:0] dur;
    w = '0;
    case (op)
      OP_TICK: begin
        if (m_run) begin
          m_elapsed = m_elapsed + 32'd1;
          if (m_pomo) begin
            dur = phase_len(m_phase);
            if (m_elapsed >= dur) begin
              m_run = 1'b0;
              m_done = 1'b1;
              m_elapsed = dur;
              w.alert = 1'b1;
            end
          end
        end
      end
      OP_MODE: begin
        m_pomo = !m_pomo;
        clear_laps();
        clear_cycle();
      end
      OP_START: begin
        if (m_pomo && m_done) advance_phase();
        else m_run = !m_run;
      end
      default: begin
        if (m_pomo) begin
          if (m_run || m_done) advance_phase();
          else clear_cycle();
        end else if (m_run) begin
          m_lap_ring[m_lap_head] = m_elapsed;
          m_lap_head = (m_lap_head + 1) % LAP_DEPTH;
          if (m_lap_fill < LAP_DEPTH) m_lap_fill++;
          if (m_laps_total != LAP_TOTAL_MAX) m_laps_total++;
        end else begin
          m_elapsed = '0;
          clear_laps();
        end
      end
    endcase
    if (m_pomo) begin
      dur = phase_len(m_phase);
      w.remaining = (m_elapsed >= dur) ? 24'd0 : 24'(dur - m_elapsed);
    end
    if (idx < m_lap_fill)
      w.lap_val = m_lap_ring[(m_lap_head + LAP_DEPTH - 1 - idx) % LAP_DEPTH];
    w.elapsed = m_elapsed;
    w.pomo = m_pomo;
    w.running = m_run;
    w.phase = m_phase;
    w.done = m_done;
    w.round = m_round;
    w.lap_total = m_laps_total;
    w.lap_fill = m_lap_fill[4:0];
    return w;
  endfunction

  // append one expected word at the tail of the queue
  function automatic void queue_word(timer_word_t w);
    words_due.insert(words_due.size(), w);
  endfunction

  function automatic void compare_field(string fname, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t ns: %s expected %0d actual %0d", $time, fname, want, got);
      mismatches++;
    end
  endfunction

  // accept input words, check result words, watch for a hang
  always @(posedge clk) begin : word_monitor
    timer_word_t want;
    if (rst) begin
      quiet_cycles <= 0;
    end else begin
      if (in_valid && in_ready === 1'b1)
        queue_word(step_timer(opcode_t'(opcode), lap_index));
      if (out_valid === 1'b1 && out_ready) begin
        if (words_due.size() == 0) begin
          $display("%0t ns: result word with none expected, elapsed_ms actual %0d",
                   $time, elapsed_ms);
          mismatches++;
        end else begin
          want = words_due.pop_front();
          compare_field("elapsed_ms", want.elapsed, elapsed_ms);
          compare_field("remaining_ms", want.remaining, remaining_ms);
          compare_field("pomodoro_mode", want.pomo, pomodoro_mode);
          compare_field("is_running", want.running, is_running);
          compare_field("phase_now", want.phase, phase_now);
          compare_field("phase_done", want.done, phase_done);
          compare_field("alert_pulse", want.alert, alert_pulse);
          compare_field("round_in_cycle", want.round, round_in_cycle);
          compare_field("laps_recorded", want.lap_total, laps_recorded);
          compare_field("laps_held", want.lap_fill, laps_held);
          compare_field("lap_time", want.lap_val, lap_time);
        end
      end
      if ((in_valid && in_ready === 1'b1) || (out_valid === 1'b1 && out_ready) || cfg_we)
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t ns: no traffic for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // receiver stalls
  always @(posedge clk) begin : stall_gen
    int n;
    if (!stalls_on) begin
      out_ready <= 1'b1;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      n = pick_gap();
      out_ready <= (n == 0);
      stall_left <= (n == 0) ? 0 : n - 1;
    end
  end

  // send one input word and wait until it is taken
  task automatic send_word(opcode_t op, logic [3:0] idx);
    int gap;
    gap = gaps_on ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    opcode <= op;
    lap_index <= idx;
    @(posedge clk);
    while (in_ready !== 1'b1) @(posedge clk);
  endtask

  task automatic send_many(opcode_t op, int count);
    repeat (count) send_word(op, 4'($urandom_range(0, 15)));
  endtask

  // drain every expected word, then let the pipe settle
  task automatic settle_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (words_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // write all four registers back to back while idle
  task automatic apply_cfg(logic [7:0] f, logic [7:0] s, logic [7:0] l, logic [3:0] c);
    settle_idle();
    cfg_we <= 1'b1;
    cfg_index <= CFG_FOCUS;
    cfg_data <= f;
    @(posedge clk);
    c_focus = f;
    cfg_index <= CFG_SHORT;
    cfg_data <= s;
    @(posedge clk);
    c_short = s;
    cfg_index <= CFG_LONG;
    cfg_data <= l;
    @(posedge clk);
    c_long = l;
    cfg_index <= CFG_CYCLES;
    cfg_data <= {4'd0, c};
    @(posedge clk);
    c_cycles = c;
    cfg_we <= 1'b0;
  endtask

  task automatic skip_phase();
    send_word(OP_START, 4'($urandom_range(0, 15)));
    send_word(OP_LAP, 4'($urandom_range(0, 15)));
  endtask

  // run, laps, out-of-range index, pause, clear, then wrap the lap ring
  task automatic test_stopwatch_laps();
    int i;
    gaps_on = 1'b1;
    stalls_on = 1'b1;
    send_word(OP_START, 4'd0);
    send_word(OP_TICK, 4'd15);
    send_many(OP_TICK, 2);
    send_word(OP_LAP, 4'd0);
    send_word(OP_TICK, 4'd0);
    send_word(OP_LAP, 4'd1);
    send_word(OP_TICK, 4'd2);
    send_word(OP_START, 4'd15);
    send_word(OP_TICK, 4'd0);
    send_word(OP_LAP, 4'd0);
    send_word(OP_START, 4'd0);
    for (i = 0; i < 20; i++) begin
      send_word(OP_TICK, 4'($urandom_range(0, 15)));
      send_word(OP_LAP, 4'($urandom_range(0, 15)));
    end
    for (i = 0; i < 16; i++) send_word(OP_TICK, 4'(i));
    send_word(OP_START, 4'd0);
    send_word(OP_LAP, 4'd15);
    send_word(OP_TICK, 4'd0);
  endtask

  // long-break selection, zero cycle length, and cycle length lowered under the count
  task automatic test_pomodoro_rounds();
    gaps_on = 1'b1;
    stalls_on = 1'b1;
    apply_cfg(8'd25, 8'd5, 8'd255, 4'd0);
    if (m_pomo) send_word(OP_MODE, 4'd0);
    send_word(OP_MODE, 4'd3);
    send_word(OP_TICK, 4'd0);
    send_word(OP_START, 4'd0);
    send_many(OP_TICK, 3);
    send_word(OP_START, 4'd0);
    send_word(OP_START, 4'd0);
    send_word(OP_LAP, 4'd0);
    repeat (3) skip_phase();
    apply_cfg(8'd1, 8'd1, 8'd1, 4'd15);
    send_word(OP_LAP, 4'd0);
    repeat (10) skip_phase();
    apply_cfg(8'd1, 8'd1, 8'd1, 4'd3);
    repeat (5) skip_phase();
    send_word(OP_LAP, 4'd0);
    apply_cfg(8'd1, 8'd1, 8'd1, 4'd15);
    repeat (32) skip_phase();
  endtask

  // zero durations read as one minute, pause and resume, duration changed mid-phase
  task automatic test_phase_countdown();
    gaps_on = 1'b0;
    stalls_on = 1'b0;
    apply_cfg(8'd0, 8'd0, 8'd0, 4'd1);
    if (m_pomo) send_word(OP_MODE, 4'd0);
    send_word(OP_MODE, 4'd0);
    send_word(OP_START, 4'd0);
    send_many(OP_TICK, 8);
    send_word(OP_START, 4'd0);
    send_many(OP_TICK, 2);
    send_word(OP_LAP, 4'd0);
    send_word(OP_START, 4'd0);
    send_many(OP_TICK, 3);
    apply_cfg(8'd3, 8'd0, 8'd255, 4'd1);
    send_many(OP_TICK, 4);
    send_word(OP_LAP, 4'd0);
    send_word(OP_START, 4'd0);
    send_many(OP_TICK, 4);
    send_word(OP_LAP, 4'd0);
  endtask

  function automatic logic [7:0] pick_minutes();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 8'd0;
    if (r == 1) return 8'd255;
    return 8'($urandom_range(1, 40));
  endfunction

  // random words in several configuration settings
  task automatic test_random_traffic();
    int blk;
    int r;
    for (blk = 0; blk < 6; blk++) begin
      apply_cfg(pick_minutes(), pick_minutes(), pick_minutes(), 4'($urandom_range(0, 15)));
      gaps_on = (blk != 2);
      stalls_on = (blk != 2);
      repeat (222) begin
        r = $urandom_range(0, 99);
        if (r < 55) send_word(OP_TICK, 4'($urandom_range(0, 15)));
        else if (r < 75) send_word(OP_START, 4'($urandom_range(0, 15)));
        else if (r < 96) send_word(OP_LAP, 4'($urandom_range(0, 15)));
        else send_word(OP_MODE, 4'($urandom_range(0, 15)));
      end
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_stopwatch_laps();
    test_pomodoro_rounds();
    test_phase_countdown();
    test_random_traffic();
    settle_idle();
    repeat (8) @(posedge clk);
    if (mismatches == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule
